// ----- rtl/dspc_pkg.sv -----
// ----------------------------------------------------------------------------
// dspc_pkg: shared types and constants of the DSP command port device
// Payload structs, bus function codes, port offsets, opcodes and reply bytes.
// ----------------------------------------------------------------------------
package dspc_pkg;

  // Default depth of the mixer register file.
  localparam int unsigned MixerDepthDefault = 256;

  // Reset values of the version registers.
  localparam logic [7:0] VersionMajorReset = 8'h04;
  localparam logic [7:0] VersionMinorReset = 8'h05;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERSION_MAJOR = 2'd0;
  localparam logic [1:0] CFG_VERSION_MINOR = 2'd1;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } dspc_func_e;

  // Port offsets from the base address.
  localparam logic [3:0] OFF_MIX_ADDR = 4'h4;
  localparam logic [3:0] OFF_MIX_DATA = 4'h5;
  localparam logic [3:0] OFF_RESET    = 4'h6;
  localparam logic [3:0] OFF_REPLY    = 4'hA;
  localparam logic [3:0] OFF_CMD      = 4'hC;
  localparam logic [3:0] OFF_STATUS   = 4'hE;

  // Command opcodes.
  localparam logic [7:0] OP_SET_RATE = 8'h41;
  localparam logic [7:0] OP_PLAY     = 8'hC0;
  localparam logic [7:0] OP_HALT     = 8'hD0;
  localparam logic [7:0] OP_SPK_ON   = 8'hD1;
  localparam logic [7:0] OP_SPK_OFF  = 8'hD3;
  localparam logic [7:0] OP_VERSION  = 8'hE1;

  // Fixed bytes.
  localparam logic [7:0] BYTE_READY   = 8'hAA;
  localparam logic [7:0] BYTE_AVAIL   = 8'h80;
  localparam logic [7:0] BYTE_UNUSED  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  typedef struct packed {
    dspc_func_e func;
    logic [3:0] port_offset;
    logic [7:0] write_data;
  } dspc_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_line;
    logic        sample_request;
    logic        playing_flag;
    logic        speaker_flag;
    logic [15:0] rate_value;
  } dspc_result_t;

  // Mixer memory access for one cycle.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } dspc_mix_req_t;

endpackage

// ----- rtl/dspc_mixer.sv -----
// ----------------------------------------------------------------------------
// dspc_mixer: mixer register file
// Single write port and one registered read port with write-through, plus a
// valid bit per entry so that entries never written read as zero.
// ----------------------------------------------------------------------------
module dspc_mixer
  import dspc_pkg::*;
#(
  parameter int unsigned MIXER_DEPTH = MixerDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dspc_mix_req_t req_i,
  output logic [7:0]    rdata_o
);

  localparam int unsigned AddrW = $clog2(MIXER_DEPTH);

  logic [7:0]             mem_q [MIXER_DEPTH];
  logic [MIXER_DEPTH-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;
  logic [AddrW-1:0]       waddr;
  logic [AddrW-1:0]       raddr;
  logic                   same_addr;

  assign waddr     = req_i.waddr[AddrW-1:0];
  assign raddr     = req_i.raddr[AddrW-1:0];
  assign same_addr = req_i.we && (waddr == raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    rdata_q <= same_addr ? req_i.wdata : mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[waddr] <= 1'b1;
      end
      rvalid_q <= same_addr || valid_q[raddr];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : BYTE_ZERO;

endmodule

// ----- rtl/dspc_core.sv -----
// ----------------------------------------------------------------------------
// dspc_core: DSP port state and command parser
// Holds the reply queue, command parser, playback counter and flags, and
// works out the next state and the result of one transaction.
// ----------------------------------------------------------------------------
module dspc_core
  import dspc_pkg::*;
#(
  parameter int unsigned MIXER_DEPTH = MixerDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  dspc_item_t    item_i,
  input  logic [7:0]    version_major_i,
  input  logic [7:0]    version_minor_i,
  input  logic [7:0]    mix_rdata_i,
  output dspc_mix_req_t mix_req_o,
  output dspc_result_t  result_o
);

  logic        armed_q, armed_d;
  logic [7:0]  reply0_q, reply0_d;
  logic [7:0]  reply1_q, reply1_d;
  logic [1:0]  rcount_q, rcount_d;
  logic [7:0]  pending_q, pending_d;
  logic [1:0]  args_q, args_d;
  logic [7:0]  arg_q, arg_d;
  logic [15:0] rate_q, rate_d;
  logic [16:0] samples_q, samples_d;
  logic        play_q, play_d;
  logic        spk_q, spk_d;
  logic        irq_q, irq_d;
  logic [7:0]  index_q, index_d;

  logic [7:0]  rd;
  logic        req;
  logic        mix_we;
  logic        mix_in_range;

  assign mix_in_range = ({1'b0, index_q} < 9'(MIXER_DEPTH));

  always_comb begin
    armed_d   = armed_q;
    reply0_d  = reply0_q;
    reply1_d  = reply1_q;
    rcount_d  = rcount_q;
    pending_d = pending_q;
    args_d    = args_q;
    arg_d     = arg_q;
    rate_d    = rate_q;
    samples_d = samples_q;
    play_d    = play_q;
    spk_d     = spk_q;
    irq_d     = irq_q;
    index_d   = index_q;
    rd        = BYTE_ZERO;
    req       = 1'b0;
    mix_we    = 1'b0;

    if (accept_i) begin
      unique case (item_i.func)
        FUNC_READ: begin
          unique case (item_i.port_offset)
            OFF_MIX_DATA: rd = mix_in_range ? mix_rdata_i : BYTE_UNUSED;
            OFF_REPLY: begin
              if (rcount_q != 2'd0) begin
                rd       = reply0_q;
                reply0_d = reply1_q;
                reply1_d = BYTE_ZERO;
                rcount_d = rcount_q - 2'd1;
              end else begin
                rd = BYTE_UNUSED;
              end
            end
            OFF_CMD: rd = BYTE_ZERO;
            OFF_STATUS: begin
              irq_d = 1'b0;
              rd    = (rcount_q != 2'd0) ? BYTE_AVAIL : BYTE_ZERO;
            end
            default: rd = BYTE_UNUSED;
          endcase
        end
        FUNC_WRITE: begin
          unique case (item_i.port_offset)
            OFF_MIX_ADDR: index_d = item_i.write_data;
            OFF_MIX_DATA: mix_we = mix_in_range;
            OFF_RESET: begin
              if (item_i.write_data[0]) begin
                armed_d = 1'b1;
              end else if (armed_q) begin
                // Soft reset keeps the rate and the mixer.
                armed_d   = 1'b0;
                reply0_d  = BYTE_READY;
                reply1_d  = BYTE_ZERO;
                rcount_d  = 2'd1;
                pending_d = BYTE_ZERO;
                args_d    = 2'd0;
                arg_d     = BYTE_ZERO;
                samples_d = '0;
                play_d    = 1'b0;
                spk_d     = 1'b0;
                irq_d     = 1'b0;
              end
            end
            OFF_CMD: begin
              if (args_q != 2'd0) begin
                // Only the previous argument byte is ever needed.
                arg_d  = item_i.write_data;
                args_d = args_q - 2'd1;
                if (args_q == 2'd1) begin
                  if (pending_q == OP_SET_RATE) begin
                    rate_d = {arg_q, item_i.write_data};
                  end else if (pending_q == OP_PLAY) begin
                    samples_d = {1'b0, item_i.write_data, arg_q} + 17'd1;
                    play_d    = 1'b1;
                  end
                end
              end else begin
                pending_d = item_i.write_data;
                arg_d     = BYTE_ZERO;
                unique case (item_i.write_data)
                  OP_SET_RATE: args_d = 2'd2;
                  OP_PLAY:     args_d = 2'd3;
                  OP_HALT: begin
                    play_d    = 1'b0;
                    samples_d = '0;
                  end
                  OP_SPK_ON:  spk_d = 1'b1;
                  OP_SPK_OFF: spk_d = 1'b0;
                  OP_VERSION: begin
                    if (rcount_q == 2'd0) begin
                      reply0_d = version_major_i;
                      reply1_d = version_minor_i;
                      rcount_d = 2'd2;
                    end else if (rcount_q == 2'd1) begin
                      reply1_d = version_major_i;
                      rcount_d = 2'd2;
                    end
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
        FUNC_TICK: begin
          if (play_q && (samples_q != '0)) begin
            req       = 1'b1;
            samples_d = samples_q - 17'd1;
            if (samples_q == 17'd1) begin
              play_d = 1'b0;
              irq_d  = 1'b1;
            end
          end
        end
        FUNC_NOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      reply0_q  <= '0;
      reply1_q  <= '0;
      rcount_q  <= '0;
      pending_q <= '0;
      args_q    <= '0;
      arg_q     <= '0;
      rate_q    <= '0;
      samples_q <= '0;
      play_q    <= 1'b0;
      spk_q     <= 1'b0;
      irq_q     <= 1'b0;
      index_q   <= '0;
    end else begin
      armed_q   <= armed_d;
      reply0_q  <= reply0_d;
      reply1_q  <= reply1_d;
      rcount_q  <= rcount_d;
      pending_q <= pending_d;
      args_q    <= args_d;
      arg_q     <= arg_d;
      rate_q    <= rate_d;
      samples_q <= samples_d;
      play_q    <= play_d;
      spk_q     <= spk_d;
      irq_q     <= irq_d;
      index_q   <= index_d;
    end
  end

  // The memory is read at the index that holds after this transaction.
  assign mix_req_o.we    = mix_we;
  assign mix_req_o.waddr = index_q;
  assign mix_req_o.wdata = item_i.write_data;
  assign mix_req_o.raddr = index_d;

  assign result_o.read_data      = rd;
  assign result_o.irq_line       = irq_d;
  assign result_o.sample_request = req;
  assign result_o.playing_flag   = play_d;
  assign result_o.speaker_flag   = spk_d;
  assign result_o.rate_value     = rate_d;

  a_play_has_samples : assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_q |-> (samples_q != '0))
    else $error("playback running with no samples left");

  a_samples_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_q <= 17'h10000)
    else $error("sample counter beyond largest block");

  a_status_acks_irq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (item_i.func == FUNC_READ) && (item_i.port_offset == OFF_STATUS))
    |=> !irq_q)
    else $error("status read did not acknowledge the interrupt");

  a_soft_reset_reply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (item_i.func == FUNC_WRITE) && (item_i.port_offset == OFF_RESET)
     && !item_i.write_data[0] && armed_q)
    |=> ((rcount_q == 2'd1) && (reply0_q == BYTE_READY) && !play_q && !armed_q))
    else $error("soft reset did not queue the ready byte");

endmodule

// ----- rtl/dsp_command_port_device.sv -----
// ----------------------------------------------------------------------------
// dsp_command_port_device: device side of an audio DSP command port
// The result of a transaction is presented in the cycle after it is
// accepted, from the output register. Throughput: one transaction per cycle,
// set by the single state update between input and output register; a new
// transaction is taken whenever the output register is empty or being drained.
// Reset: asynchronous, all state clears at once; the mixer reads as zero via
// per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module dsp_command_port_device
  import dspc_pkg::*;
#(
  parameter int unsigned MIXER_DEPTH = MixerDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dspc_item_t   in_item_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output dspc_result_t out_result_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  logic          accept;
  logic [7:0]    ver_major_q;
  logic [7:0]    ver_minor_q;
  logic          out_valid_q;
  dspc_result_t  out_result_q;
  dspc_result_t  result;
  dspc_mix_req_t mix_req;
  logic [7:0]    mix_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_major_q <= VersionMajorReset;
      ver_minor_q <= VersionMinorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VERSION_MAJOR: ver_major_q <= cfg_data_i;
        CFG_VERSION_MINOR: ver_minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dspc_core #(
    .MIXER_DEPTH(MIXER_DEPTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_item_i),
    .version_major_i(ver_major_q),
    .version_minor_i(ver_minor_q),
    .mix_rdata_i    (mix_rdata),
    .mix_req_o      (mix_req),
    .result_o       (result)
  );

  dspc_mixer #(
    .MIXER_DEPTH(MIXER_DEPTH)
  ) u_mixer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mix_req),
    .rdata_o(mix_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;

endmodule
